// ----- rtl/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and saturation helpers shared by the PID controller with
// feedforward.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int WORD_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PERIOD_FRAC = WORD_WIDTH - 8;
    localparam int DIV_STEPS   = FRAC_BITS + PERIOD_FRAC;
    localparam int ADDR_WIDTH  = 5;

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic signed [WORD_WIDTH:0]   ext_t;
    typedef logic signed [WORD_WIDTH+2:0] wide_t;
    typedef logic        [WORD_WIDTH-2:0] limit_t;

    localparam word_t WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [2:0] REG_SP_RATE_GAIN  = 3'd2;
    localparam logic [2:0] REG_FB_RATE_GAIN  = 3'd3;
    localparam logic [2:0] REG_FF_GAIN       = 3'd4;
    localparam logic [2:0] REG_ERROR_CLAMP   = 3'd5;
    localparam logic [2:0] REG_INTEG_CLAMP   = 3'd6;
    localparam logic [2:0] REG_OUTPUT_CLAMP  = 3'd7;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] period;
        word_t                 feedforward;
        word_t                 setpoint;
        word_t                 measured;
        logic                  use_external_rate;
        word_t                 external_rate;
    } in_item_t;

    typedef struct packed {
        word_t drive;
        word_t integral_now;
    } out_item_t;

    typedef struct packed {
        word_t  prop_gain;
        word_t  integral_gain;
        word_t  setpoint_rate_gain;
        word_t  feedback_rate_gain;
        word_t  feedforward_gain;
        limit_t error_clamp;
        limit_t integral_clamp;
        limit_t output_clamp;
    } cfg_t;

    function automatic ext_t sext_word(input word_t x);
        return {x[WORD_WIDTH-1], x};
    endfunction

    function automatic wide_t widen(input word_t x);
        return {{3{x[WORD_WIDTH-1]}}, x};
    endfunction

    function automatic word_t sat_word(input wide_t x);
        if (x > widen(WMAX))
            return WMAX;
        else if (x < widen(WMIN))
            return WMIN;
        else
            return x[WORD_WIDTH-1:0];
    endfunction

    function automatic word_t clamp_sym(input word_t x, input limit_t lim);
        word_t l;
        l = {1'b0, lim};
        if (x > l)
            return l;
        else if (x < -l)
            return -l;
        else
            return x;
    endfunction

endpackage

// ----- rtl/pfc_regs.sv -----
// ----------------------------------------------------------------------------
// pfc_regs
// APB-style configuration registers: gains and clamp limits.
// ----------------------------------------------------------------------------
module pfc_regs
    import pfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[ADDR_WIDTH-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_PROP_GAIN:     cfg_reg.prop_gain          <= pwdata;
                REG_INTEGRAL_GAIN: cfg_reg.integral_gain      <= pwdata;
                REG_SP_RATE_GAIN:  cfg_reg.setpoint_rate_gain <= pwdata;
                REG_FB_RATE_GAIN:  cfg_reg.feedback_rate_gain <= pwdata;
                REG_FF_GAIN:       cfg_reg.feedforward_gain   <= pwdata;
                REG_ERROR_CLAMP:   cfg_reg.error_clamp        <= pwdata[WORD_WIDTH-2:0];
                REG_INTEG_CLAMP:   cfg_reg.integral_clamp     <= pwdata[WORD_WIDTH-2:0];
                REG_OUTPUT_CLAMP:  cfg_reg.output_clamp       <= pwdata[WORD_WIDTH-2:0];
                default:           cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_PROP_GAIN:     prdata = cfg_reg.prop_gain;
            REG_INTEGRAL_GAIN: prdata = cfg_reg.integral_gain;
            REG_SP_RATE_GAIN:  prdata = cfg_reg.setpoint_rate_gain;
            REG_FB_RATE_GAIN:  prdata = cfg_reg.feedback_rate_gain;
            REG_FF_GAIN:       prdata = cfg_reg.feedforward_gain;
            REG_ERROR_CLAMP:   prdata = {1'b0, cfg_reg.error_clamp};
            REG_INTEG_CLAMP:   prdata = {1'b0, cfg_reg.integral_clamp};
            REG_OUTPUT_CLAMP:  prdata = {1'b0, cfg_reg.output_clamp};
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- rtl/pfc_recip.sv -----
// ----------------------------------------------------------------------------
// pfc_recip
// Restoring divider, one quotient bit per cycle: rate = 2^DIV_STEPS / period,
// saturated to the largest positive word; zero period gives zero rate.
// ----------------------------------------------------------------------------
module pfc_recip
    import pfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_WIDTH-1:0] period,
    output word_t                 rate,
    output logic                  ready
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [WORD_WIDTH-1:0] p_reg;
    logic [WORD_WIDTH-1:0] rem_reg;
    logic [WORD_WIDTH-2:0] q_reg;
    logic                  sat_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  ready_reg;

    logic [WORD_WIDTH:0]   rem_shift;
    logic                  take;
    logic [WORD_WIDTH:0]   rem_sub;
    logic [WORD_WIDTH-1:0] rem_next;
    logic [WORD_WIDTH-1:0] q_next;

    assign rem_shift = {rem_reg, 1'b0};
    assign take      = rem_shift >= {1'b0, p_reg};
    assign rem_sub   = rem_shift - {1'b0, p_reg};
    assign rem_next  = take ? rem_sub[WORD_WIDTH-1:0] : rem_shift[WORD_WIDTH-1:0];
    assign q_next    = {q_reg, take};

    assign rate  = sat_reg ? WMAX : {1'b0, q_reg};
    assign ready = ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            ready_reg <= 1'b0;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else if (start)
        begin
            p_reg   <= period;
            cnt_reg <= '0;
            sat_reg <= 1'b0;
            if (period == '0)
            begin
                q_reg     <= '0;
                rem_reg   <= '0;
                busy_reg  <= 1'b0;
                ready_reg <= 1'b1;
            end
            else
            begin
                q_reg     <= (period == WORD_WIDTH'(1)) ? (WORD_WIDTH-1)'(1) : '0;
                rem_reg   <= (period == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
                busy_reg  <= 1'b1;
                ready_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next[WORD_WIDTH-2:0];
            sat_reg <= sat_reg | q_next[WORD_WIDTH-1];
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg  <= 1'b0;
                ready_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/pfc_mul.sv -----
// ----------------------------------------------------------------------------
// pfc_mul
// Shared fixed-point multiplier: sign-magnitude product, shifted right by the
// fraction bits (by PERIOD_FRAC when long_shift is set) with truncation toward
// zero, saturated to the word range. Three-stage pipeline, one operation in
// flight under the sequencer.
module pfc_mul
    import pfc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  long_shift,
    input  ext_t  op_a,
    input  ext_t  op_b,
    output word_t result,
    output logic  done
);

    localparam int PW = 2 * WORD_WIDTH;

    ext_t                  abs_a;
    ext_t                  abs_b;

    logic [WORD_WIDTH-1:0] mag_a_reg;
    logic [WORD_WIDTH-1:0] mag_b_reg;
    logic                  neg1_reg;
    logic                  lsh1_reg;
    logic                  v1_reg;

    logic [PW-1:0]         prod_reg;
    logic                  neg2_reg;
    logic                  lsh2_reg;
    logic                  v2_reg;

    logic [PW-1:0]         shifted;
    logic [PW-1:0]         lim;
    logic [PW-1:0]         mag_r;
    word_t                 result_next;
    word_t                 result_reg;
    logic                  done_reg;

    assign abs_a = op_a[WORD_WIDTH] ? -op_a : op_a;
    assign abs_b = op_b[WORD_WIDTH] ? -op_b : op_b;

    assign shifted = lsh2_reg ? (prod_reg >> PERIOD_FRAC) : (prod_reg >> FRAC_BITS);
    assign lim     = PW'(WMAX) + PW'(neg2_reg);
    assign mag_r   = (shifted > lim) ? lim : shifted;
    assign result_next = neg2_reg ? -word_t'(mag_r[WORD_WIDTH-1:0])
                                  : word_t'(mag_r[WORD_WIDTH-1:0]);

    assign result = result_reg;
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg  <= abs_a[WORD_WIDTH-1:0];
        mag_b_reg  <= abs_b[WORD_WIDTH-1:0];
        neg1_reg   <= op_a[WORD_WIDTH] ^ op_b[WORD_WIDTH];
        lsh1_reg   <= long_shift;
        prod_reg   <= PW'(mag_a_reg) * PW'(mag_b_reg);
        neg2_reg   <= neg1_reg;
        lsh2_reg   <= lsh1_reg;
        result_reg <= result_next;
    end

endmodule

// ----- rtl/pid_feedforward_controller.sv -----
// ----------------------------------------------------------------------------
// pid_feedforward_controller
// One PID step with feedforward per sample: rate from the period, setpoint and
// feedback derivatives, clamped integrator, clamped drive output.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_stall  in_item_t
//   result    out        result_valid / result_stall  out_item_t
//   config    in         APB-style write/read         32-bit registers
//
// The 40-step divider for the rate runs beside the first four multiplies.
// A result waits in the output register and the next sample is taken meanwhile;
// a step holds its final state while that register is still stalled.
// Reset clears the integrator and the previous setpoint and feedback.
// ----------------------------------------------------------------------------
module pid_feedforward_controller
    import pfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  in_item_t              sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_item_t             result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_RATE  = 3'd4;
    localparam logic [2:0] S_SUM1  = 3'd5;
    localparam logic [2:0] S_SUM2  = 3'd6;

    localparam logic [2:0] OP_KI_ERR = 3'd0;
    localparam logic [2:0] OP_INC    = 3'd1;
    localparam logic [2:0] OP_FF     = 3'd2;
    localparam logic [2:0] OP_KP     = 3'd3;
    localparam logic [2:0] OP_SP_D   = 3'd4;
    localparam logic [2:0] OP_FB_D   = 3'd5;
    localparam logic [2:0] OP_KDSP   = 3'd6;
    localparam logic [2:0] OP_KDFB   = 3'd7;

    cfg_t      cfg;
    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] op_reg;
    logic [2:0] op_next;

    in_item_t  item_reg;
    word_t     last_sp_reg;
    word_t     last_meas_reg;
    word_t     integ_reg;
    word_t     err_reg;
    word_t     tmp_reg;
    word_t     spd_reg;
    word_t     fbd_reg;
    word_t     deriv_reg;
    wide_t     fp_reg;
    wide_t     acc_reg;
    out_item_t result_reg;
    logic      result_valid_reg;

    logic      div_start;
    word_t     rate;
    logic      rate_ready;
    logic      mul_start;
    logic      long_shift;
    ext_t      op_a;
    ext_t      op_b;
    word_t     mul_res;
    logic      mul_done;
    logic      out_free;

    pfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfc_recip u_recip (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .period (item_reg.period),
        .rate   (rate),
        .ready  (rate_ready)
    );

    pfc_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mul_start),
        .long_shift (long_shift),
        .op_a       (op_a),
        .op_b       (op_b),
        .result     (mul_res),
        .done       (mul_done)
    );

    assign sample_stall = (state_reg != S_IDLE);
    assign div_start    = (state_reg == S_PREP);
    assign mul_start    = (state_reg == S_ISSUE);
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        long_shift = 1'b0;
        op_a       = sext_word(cfg.integral_gain);
        op_b       = sext_word(clamp_sym(err_reg, cfg.error_clamp));
        case (op_reg)
            OP_KI_ERR:
            begin
                op_a = sext_word(cfg.integral_gain);
                op_b = sext_word(clamp_sym(err_reg, cfg.error_clamp));
            end
            OP_INC:
            begin
                long_shift = 1'b1;
                op_a       = sext_word(tmp_reg);
                op_b       = {1'b0, item_reg.period};
            end
            OP_FF:
            begin
                op_a = sext_word(cfg.feedforward_gain);
                op_b = sext_word(item_reg.feedforward);
            end
            OP_KP:
            begin
                op_a = sext_word(cfg.prop_gain);
                op_b = sext_word(err_reg);
            end
            OP_SP_D:
            begin
                op_a = sext_word(item_reg.setpoint) - sext_word(last_sp_reg);
                op_b = sext_word(rate);
            end
            OP_FB_D:
            begin
                op_a = sext_word(item_reg.measured) - sext_word(last_meas_reg);
                op_b = sext_word(rate);
            end
            OP_KDSP:
            begin
                op_a = sext_word(cfg.setpoint_rate_gain);
                op_b = sext_word(spd_reg);
            end
            OP_KDFB:
            begin
                op_a = sext_word(cfg.feedback_rate_gain);
                op_b = sext_word(fbd_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                op_next    = OP_KI_ERR;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    op_next = op_reg + 3'd1;
                    if (op_reg == OP_KP)
                        state_next = S_RATE;
                    else if (op_reg == OP_KDFB)
                        state_next = S_SUM1;
                    else
                        state_next = S_ISSUE;
                end
            end
            S_RATE:
            begin
                if (rate_ready)
                    state_next = S_ISSUE;
            end
            S_SUM1:
            begin
                state_next = S_SUM2;
            end
            S_SUM2:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_KI_ERR;
            result_valid_reg <= 1'b0;
            last_sp_reg      <= '0;
            last_meas_reg    <= '0;
            integ_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;

            if (state_reg == S_WAIT && mul_done && op_reg == OP_INC)
                integ_reg <= clamp_sym(sat_word(widen(integ_reg) + widen(mul_res)),
                                       cfg.integral_clamp);

            if (state_reg == S_SUM2 && out_free)
            begin
                result_valid_reg <= 1'b1;
                last_sp_reg      <= item_reg.setpoint;
                last_meas_reg    <= item_reg.measured;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && sample_valid)
            item_reg <= sample;

        if (state_reg == S_PREP)
            err_reg <= sat_word(widen(item_reg.setpoint) - widen(item_reg.measured));

        if (state_reg == S_WAIT && mul_done)
        begin
            case (op_reg)
                OP_KI_ERR: tmp_reg   <= mul_res;
                OP_FF:     fp_reg    <= widen(mul_res);
                OP_KP:     fp_reg    <= fp_reg + widen(mul_res);
                OP_SP_D:   spd_reg   <= mul_res;
                OP_FB_D:   fbd_reg   <= item_reg.use_external_rate ? item_reg.external_rate
                                                                   : mul_res;
                OP_KDSP:   tmp_reg   <= mul_res;
                OP_KDFB:   deriv_reg <= sat_word(widen(tmp_reg) - widen(mul_res));
                default:   tmp_reg   <= tmp_reg;
            endcase
        end

        if (state_reg == S_SUM1)
            acc_reg <= fp_reg + widen(deriv_reg);

        if (state_reg == S_SUM2 && out_free)
        begin
            result_reg.drive        <= clamp_sym(sat_word(acc_reg + widen(integ_reg)),
                                                 cfg.output_clamp);
            result_reg.integral_now <= integ_reg;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PID controller with feedforward. Samples are
// queued by the stimulus process and sent by a clocked driver, which predicts
// each control step at the moment of transfer. A clocked monitor compares
// each result with the oldest prediction. Gains and clamps are set over the
// APB port between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_top
    import pfc_pkg::*;
();

    localparam int     PHASE_ITEMS = 366;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam longint WORD_HI     = (64'sd1 <<< (WORD_WIDTH - 1)) - 1;
    localparam longint WORD_LO     = -WORD_HI - 1;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr        = '0;
    logic [31:0]           pwdata       = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    in_item_t              sample       = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    out_item_t             result;

    in_item_t  sample_backlog[$];
    out_item_t due_outputs[$];
    out_item_t want;
    cfg_t      gains       = '0;
    longint    prev_sp     = 0;
    longint    prev_meas   = 0;
    longint    integ_acc   = 0;
    word_t     sp_walk     = '0;
    word_t     meas_walk   = '0;
    bit        quiet       = 1'b0;
    int        gap_left    = 0;
    int        stall_left  = 0;
    int        mismatches  = 0;
    int        results_in  = 0;
    int        cycles      = 0;

    pid_feedforward_controller DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint saturate(input longint x);
        if (x > WORD_HI)
            return WORD_HI;
        if (x < WORD_LO)
            return WORD_LO;
        return x;
    endfunction

    function automatic longint clamp_to(input longint x, input limit_t lim);
        longint l;
        l = longint'({1'b0, lim});
        if (x > l)
            return l;
        if (x < -l)
            return -l;
        return x;
    endfunction

    // truncate the magnitude toward zero, then saturate
    function automatic longint scaled_product(input longint a, input longint b,
                                              input int unsigned sh);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] mag;
        logic [127:0] cap;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        mag = ({64'd0, ua} * {64'd0, ub}) >> sh;
        cap = neg ? 128'(WORD_HI) + 128'd1 : 128'(WORD_HI);
        if (mag > cap)
            mag = cap;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint rate_of(input logic [WORD_WIDTH-1:0] p);
        logic [63:0] q;
        if (p == '0)
            return 0;
        q = (64'd1 << DIV_STEPS) / {32'd0, p};
        return (q > 64'(WORD_HI)) ? WORD_HI : longint'(q);
    endfunction

    function automatic out_item_t control_step(input in_item_t s);
        longint    hz;
        longint    sp;
        longint    meas;
        longint    sp_rate;
        longint    fb_rate;
        longint    rate_term;
        longint    err;
        longint    inc;
        longint    drive;
        out_item_t r;
        sp      = longint'(s.setpoint);
        meas    = longint'(s.measured);
        hz      = rate_of(s.period);
        sp_rate = scaled_product(sp - prev_sp, hz, FRAC_BITS);
        fb_rate = s.use_external_rate ? longint'(s.external_rate)
                                      : scaled_product(meas - prev_meas, hz, FRAC_BITS);
        rate_term = saturate(
            scaled_product(longint'(gains.setpoint_rate_gain), sp_rate, FRAC_BITS)
            - scaled_product(longint'(gains.feedback_rate_gain), fb_rate, FRAC_BITS));
        err = saturate(sp - meas);
        inc = scaled_product(
            scaled_product(longint'(gains.integral_gain),
                           clamp_to(err, gains.error_clamp), FRAC_BITS),
            longint'({32'd0, s.period}), PERIOD_FRAC);
        integ_acc = clamp_to(saturate(integ_acc + inc), gains.integral_clamp);
        drive = saturate(
            scaled_product(longint'(gains.feedforward_gain),
                           longint'(s.feedforward), FRAC_BITS)
            + scaled_product(longint'(gains.prop_gain), err, FRAC_BITS)
            + rate_term + integ_acc);
        drive     = clamp_to(drive, gains.output_clamp);
        prev_sp   = sp;
        prev_meas = meas;
        r.drive        = drive[WORD_WIDTH-1:0];
        r.integral_now = integ_acc[WORD_WIDTH-1:0];
        return r;
    endfunction

    function automatic in_item_t make_sample(input logic [WORD_WIDTH-1:0] period,
                                             input word_t ff, input word_t sp,
                                             input word_t meas, input logic ext_on,
                                             input word_t ext);
        in_item_t s;
        s.period            = period;
        s.feedforward       = ff;
        s.setpoint          = sp;
        s.measured          = meas;
        s.use_external_rate = ext_on;
        s.external_rate     = ext;
        return s;
    endfunction

    function automatic word_t signed_upto(input int unsigned bits);
        word_t v;
        v = $urandom_range(0, (32'd1 << bits) - 32'd1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic word_t gain_pick();
        case ($urandom_range(0, 9))
            0:       return WMAX;
            1:       return WMIN;
            2:       return '0;
            3:       return signed_upto(31);
            default: return signed_upto(18);
        endcase
    endfunction

    function automatic limit_t clamp_pick();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return '0;
            2:       return limit_t'($urandom);
            default: return limit_t'($urandom_range(1, 32'd1 << 24));
        endcase
    endfunction

    // mostly a tracking loop on a slow walk, sometimes raw noise
    function automatic in_item_t random_sample();
        logic [WORD_WIDTH-1:0] period;
        in_item_t              s;
        if ($urandom_range(0, 4) != 0)
        begin
            sp_walk   = sp_walk + signed_upto(15);
            meas_walk = meas_walk + ((sp_walk - meas_walk) >>> 2) + signed_upto(12);
            period    = $urandom_range(32'd1 << 12, 32'd1 << 20);
            s = make_sample(period, signed_upto(20), sp_walk, meas_walk,
                            $urandom_range(0, 3) == 0, signed_upto(20));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       period = '0;
                1:       period = $urandom_range(1, 1024);
                2:       period = $urandom;
                default: period = $urandom_range(32'd1 << 20, 32'd1 << 28);
            endcase
            s = make_sample(period, $urandom, $urandom, $urandom,
                            1'($urandom_range(0, 1)), $urandom);
            sp_walk   = s.setpoint;
            meas_walk = s.measured;
        end
        return s;
    endfunction

    task automatic report(input string what, input word_t got, input word_t want_word);
        $display("mismatch on %s of result %0d: got %h, expected %h",
                 what, results_in, got, want_word);
        mismatches++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROP_GAIN:     gains.prop_gain          = value;
            REG_INTEGRAL_GAIN: gains.integral_gain      = value;
            REG_SP_RATE_GAIN:  gains.setpoint_rate_gain = value;
            REG_FB_RATE_GAIN:  gains.feedback_rate_gain = value;
            REG_FF_GAIN:       gains.feedforward_gain   = value;
            REG_ERROR_CLAMP:   gains.error_clamp        = value[WORD_WIDTH-2:0];
            REG_INTEG_CLAMP:   gains.integral_clamp     = value[WORD_WIDTH-2:0];
            REG_OUTPUT_CLAMP:  gains.output_clamp       = value[WORD_WIDTH-2:0];
            default: ;
        endcase
    endtask

    task automatic set_gains(input word_t kp, input word_t ki, input word_t kdsp,
                             input word_t kdfb, input word_t kff, input limit_t ec,
                             input limit_t ic, input limit_t oc);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEGRAL_GAIN, ki);
        write_reg(REG_SP_RATE_GAIN, kdsp);
        write_reg(REG_FB_RATE_GAIN, kdfb);
        write_reg(REG_FF_GAIN, kff);
        write_reg(REG_ERROR_CLAMP, {1'b0, ec});
        write_reg(REG_INTEG_CLAMP, {1'b0, ic});
        write_reg(REG_OUTPUT_CLAMP, {1'b0, oc});
        @(negedge clk);
    endtask

    task automatic drain();
        while (sample_backlog.size() != 0 || sample_valid || due_outputs.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            gap_left     <= 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                due_outputs.push_back(control_step(sample));
            if (!sample_valid || !sample_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left     <= gap_left - 1;
                    sample_valid <= 1'b0;
                end
                else if (sample_backlog.size() == 0)
                begin
                    sample_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 5) == 0)
                begin
                    gap_left     <= $urandom_range(0, 5);
                    sample_valid <= 1'b0;
                end
                else
                begin
                    sample       <= sample_backlog.pop_front();
                    sample_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_in++;
                if (due_outputs.size() == 0)
                begin
                    report("unexpected transfer", result.drive, '0);
                end
                else
                begin
                    want = due_outputs.pop_front();
                    if (result.drive !== want.drive)
                        report("drive", result.drive, want.drive);
                    if (result.integral_now !== want.integral_now)
                        report("integral_now", result.integral_now, want.integral_now);
                end
            end
            if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left   <= $urandom_range(0, 5);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset gains and zero clamps
        sample_backlog.push_back(make_sample(32'h0100_0000, 1000, 65536, 0, 1'b0, 0));
        sample_backlog.push_back(make_sample('0, WMAX, WMIN, WMAX, 1'b1, WMIN));
        drain();

        set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'h0000_0200,
                  32'h0001_0000, 31'h0010_0000, 31'h0040_0000, 31'h0100_0000);
        sample_backlog.push_back(make_sample(16777, 0, 65536, 0, 1'b0, 0));
        sample_backlog.push_back(make_sample('0, 0, 131072, 1000, 1'b0, 0));
        sample_backlog.push_back(make_sample(1, 0, 0, 65536, 1'b0, 0));
        sample_backlog.push_back(make_sample('1, 0, 100, 50, 1'b0, 0));
        sample_backlog.push_back(make_sample(511, 0, 200, 0, 1'b0, 0));
        sample_backlog.push_back(make_sample(512, 0, 300, 10, 1'b0, 0));
        sample_backlog.push_back(make_sample(513, 0, 400, 20, 1'b0, 0));
        sample_backlog.push_back(make_sample(16777, 0, WMAX, WMIN, 1'b0, 0));
        sample_backlog.push_back(make_sample(16777, 0, WMIN, WMAX, 1'b0, 0));
        sample_backlog.push_back(make_sample(16777, WMAX, 0, 0, 1'b0, 0));
        sample_backlog.push_back(make_sample(16777, WMIN, 0, 0, 1'b0, 0));
        sample_backlog.push_back(make_sample(16777, 0, 5000, 0, 1'b1, WMAX));
        sample_backlog.push_back(make_sample(16777, 0, 5000, 0, 1'b1, WMIN));
        sample_backlog.push_back(make_sample(16777, 65536, 5000, 0, 1'b1, 0));
        // wind the integrator up toward its clamp, then back the other way
        repeat (5)
            sample_backlog.push_back(make_sample(32'h0100_0000, 0, 32'h0010_0000, 0,
                                                 1'b0, 0));
        repeat (4)
            sample_backlog.push_back(make_sample(32'h0100_0000, 0, WMIN, WMAX, 1'b0, 0));
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:       set_gains(WMAX, WMAX, WMAX, WMAX, WMAX, '1, '1, '1);
                2:       set_gains(WMIN, WMIN, WMIN, WMIN, WMIN, '0, '0, '0);
                default: set_gains(gain_pick(), gain_pick(), gain_pick(), gain_pick(),
                                   gain_pick(), clamp_pick(), clamp_pick(), clamp_pick());
            endcase
            quiet = (phase == 2 || phase == 4);
            repeat (PHASE_ITEMS)
                sample_backlog.push_back(random_sample());
            drain();
        end

        repeat (80) @(posedge clk);
        if (mismatches == 0 && due_outputs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
